FILE: design/kr_pkg.sv
// ----------------------------------------------------------------------------
// kr_pkg
// Shared types and constants for the keypad scanner with typematic repeat
// and key queue: request payloads, register map, sequencer states and the
// control and status bundles between the top level and the key queue.
// ----------------------------------------------------------------------------
package kr_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 31;
    localparam int KEY_W   = 3;
    localparam int LEVEL_W = 8;
    localparam int MAP_W   = 8;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;

    localparam logic [CFG_W-1:0] DELAY_RST    = 31'd400000;
    localparam logic [CFG_W-1:0] INTERVAL_RST = 31'd100000;
    localparam logic [CFG_W-1:0] RELEASE_RST  = 31'd50000;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_GET    = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_RETURN = 2'd3
    } kr_op_t;

    typedef enum logic [1:0] {
        REG_DELAY    = 2'd0,
        REG_INTERVAL = 2'd1,
        REG_RELEASE  = 2'd2
    } kr_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH,
        ST_RESOLVE,
        ST_READ
    } kr_state_t;

    typedef struct packed {
        kr_op_t               opcode;
        logic [TIME_W-1:0]    now_time;
        logic [LEVEL_W-1:0]   button_levels;
        logic [KEY_W-1:0]     return_key;
    } kr_in_t;

    typedef struct packed {
        logic                 key_valid;
        logic [KEY_W-1:0]     key_code;
        logic [MAP_W-1:0]     press_map;
    } kr_out_t;

    // Commands from the sequencer to the key queue
    typedef struct packed {
        logic load;
        logic step;
        logic get;
        logic flush;
        logic hold;
    } kr_qctl_t;

    // Status from the key queue to the sequencer
    typedef struct packed {
        logic busy;
        logic held_valid;
        logic ring_nonempty;
    } kr_qsts_t;

endpackage

FILE: design/kr_ram.sv
// ----------------------------------------------------------------------------
// kr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kr_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/kr_lane.sv
// ----------------------------------------------------------------------------
// kr_lane
// One button lane: pressed flag, repeat base and last-pressed time, and the
// push request for a new press or a due repeat.
// ----------------------------------------------------------------------------
module kr_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       down,
    input  logic [kr_pkg::TIME_W-1:0]  now_time,
    input  logic [kr_pkg::TIME_W-1:0]  rep_offset,
    input  logic [kr_pkg::CFG_W-1:0]   rep_interval,
    input  logic [kr_pkg::CFG_W-1:0]   rel_time,
    output logic                       push,
    output logic                       pressed
);

    import kr_pkg::*;

    logic              flag_reg, flag_next;
    logic [TIME_W-1:0] base_reg, base_next;
    logic [TIME_W-1:0] seen_reg, seen_next;

    // Signed wrapping difference reaches a non-negative limit
    function automatic logic reached(input logic [TIME_W-1:0] now_t,
                                     input logic [TIME_W-1:0] then_t,
                                     input logic [CFG_W-1:0]  limit);
        logic [TIME_W-1:0] d;
        begin
            d = now_t - then_t;
            return !d[TIME_W-1] && (d[CFG_W-1:0] >= limit);
        end
    endfunction

    always_comb begin
        flag_next = flag_reg;
        base_next = base_reg;
        seen_next = seen_reg;
        push      = 1'b0;
        if (en) begin
            if (down) begin
                if (!flag_reg) begin
                    base_next = now_time + rep_offset;
                    flag_next = 1'b1;
                    push      = 1'b1;
                end else if (reached(now_time, base_reg, rep_interval)) begin
                    base_next = now_time;
                    push      = 1'b1;
                end
                seen_next = now_time;
            end else if (flag_reg && reached(now_time, seen_reg, rel_time)) begin
                flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
            base_reg <= '0;
            seen_reg <= '0;
        end else begin
            flag_reg <= flag_next;
            base_reg <= base_next;
            seen_reg <= seen_next;
        end
    end

    assign pressed = flag_reg;

endmodule

FILE: design/kr_queue.sv
// ----------------------------------------------------------------------------
// kr_queue
// Merging stage and key queue: takes the lanes' push mask, retires one key a
// cycle in index order into a ring that keeps one slot empty (dropped when the
// ring is full), and serves gets from the one-key holder first, then the ring.
// ----------------------------------------------------------------------------
module kr_queue #(
    parameter int BUTTONS    = 8,
    parameter int RING_SLOTS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  kr_pkg::kr_qctl_t          ctl,
    input  logic [BUTTONS-1:0]        push_mask,
    input  logic [kr_pkg::KEY_W-1:0]  return_key,
    output kr_pkg::kr_qsts_t          sts,
    output logic [kr_pkg::KEY_W-1:0]  held_key,
    output logic [kr_pkg::KEY_W-1:0]  ring_key
);

    import kr_pkg::*;

    localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int PTR_W = $clog2(RING_SLOTS);

    logic [BUTTONS-1:0] mask_reg, mask_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [KEY_W-1:0]   held_key_reg, held_key_next;
    logic               held_valid_reg, held_valid_next;
    logic [IDX_W-1:0]   idx;
    logic [PTR_W-1:0]   wp_inc;
    logic [PTR_W-1:0]   rp_inc;
    logic               we;

    // Lowest pending button goes first
    always_comb begin
        idx = '0;
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign wp_inc = (wp_reg == PTR_W'(RING_SLOTS - 1)) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc = (rp_reg == PTR_W'(RING_SLOTS - 1)) ? '0 : rp_reg + PTR_W'(1);

    always_comb begin
        mask_next       = mask_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        held_key_next   = held_key_reg;
        held_valid_next = held_valid_reg;
        we              = 1'b0;
        if (ctl.load) begin
            mask_next = push_mask;
        end else if (ctl.step) begin
            mask_next = mask_reg & (mask_reg - BUTTONS'(1));
            if (wp_inc != rp_reg) begin
                we      = 1'b1;
                wp_next = wp_inc;
            end
        end
        if (ctl.flush) begin
            rp_next         = wp_reg;
            held_valid_next = 1'b0;
        end
        if (ctl.hold) begin
            held_key_next   = return_key;
            held_valid_next = 1'b1;
        end
        if (ctl.get) begin
            if (held_valid_reg) begin
                held_valid_next = 1'b0;
            end else begin
                rp_next = rp_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg       <= '0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            held_key_reg   <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            mask_reg       <= mask_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            held_key_reg   <= held_key_next;
            held_valid_reg <= held_valid_next;
        end
    end

    kr_ram #(
        .WIDTH (KEY_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .aclk  (aclk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (KEY_W'(idx)),
        .raddr (rp_reg),
        .rdata (ring_key)
    );

    assign sts.busy          = |mask_reg;
    assign sts.held_valid    = held_valid_reg;
    assign sts.ring_nonempty = (rp_reg != wp_reg);
    assign held_key          = held_key_reg;

`ifndef SYNTH
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg <= PTR_W'(RING_SLOTS - 1)) && (rp_reg <= PTR_W'(RING_SLOTS - 1)))
        else $error("ring pointer out of range");

    a_step_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.step |=> ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("push step did not retire exactly one button");

    a_get_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.get |-> (held_valid_reg || (rp_reg != wp_reg)))
        else $error("get issued with nothing to return");
`endif

endmodule

FILE: design/keypad_repeat_fifo.sv
// Sequencing: an accepted request passes the scan, push and resolve states, and
// a get that pops the ring also the read state; the merging stage in the push
// state takes one key per cycle, dropped keys included. A new request is only
// accepted once the block is idle again, after the last result is loaded.
// Reset: synchronous active-low; clears flags, pointers and holder at once,
// configuration registers take their default values, ring contents stay undefined.
// ----------------------------------------------------------------------------
// keypad_repeat_fifo
// Button scanner with typematic repeat and a key queue. One lane per button
// tracks press, repeat and release timing in parallel; the queue merges the
// lanes' new keys in index order into a ring and serves get requests.
// ----------------------------------------------------------------------------
module keypad_repeat_fifo #(
    parameter int RING_SLOTS = 16,
    parameter int BUTTONS    = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kr_pkg::ADDR_W-1:0]  paddr,
    input  logic [kr_pkg::APB_W-1:0]   pwdata,
    output logic [kr_pkg::APB_W-1:0]   prdata,
    output logic                       pready,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  kr_pkg::kr_in_t             s_data,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output kr_pkg::kr_out_t            m_data
);

    import kr_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] delay_reg, delay_next;
    logic [CFG_W-1:0] interval_reg, interval_next;
    logic [CFG_W-1:0] release_reg, release_next;

    // Sequencer and request holding
    kr_state_t        state_reg, state_next;
    kr_in_t           item_reg, item_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    kr_out_t          m_data_reg, m_data_next;
    logic             out_free;
    logic             out_load;

    // Lanes and queue
    logic [TIME_W-1:0]  rep_offset;
    logic               lane_en;
    logic [BUTTONS-1:0] down;
    logic [BUTTONS-1:0] push_vec;
    logic [BUTTONS-1:0] flags;
    logic [MAP_W-1:0]   press_map;
    kr_qctl_t           qctl;
    kr_qsts_t           qsts;
    logic [KEY_W-1:0]   held_key;
    logic [KEY_W-1:0]   ring_key;
    logic               cfg_wr;
    logic               accept;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait writes, register i at byte 4*i
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        delay_next    = delay_reg;
        interval_next = interval_reg;
        release_next  = release_reg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DELAY:    delay_next    = pwdata[CFG_W-1:0];
                REG_INTERVAL: interval_next = pwdata[CFG_W-1:0];
                REG_RELEASE:  release_next  = pwdata[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DELAY:    prdata = {1'b0, delay_reg};
            REG_INTERVAL: prdata = {1'b0, interval_reg};
            REG_RELEASE:  prdata = {1'b0, release_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= DELAY_RST;
            interval_reg <= INTERVAL_RST;
            release_reg  <= RELEASE_RST;
        end else begin
            delay_reg    <= delay_next;
            interval_reg <= interval_next;
            release_reg  <= release_next;
        end
    end

    // First repeat lands repeat_delay after the press: seed the repeat base
    // one interval early so every repeat uses the same interval compare.
    assign rep_offset = {1'b0, delay_reg} - {1'b0, interval_reg};

    // ------------------------------------------------------------------
    // Button lanes: on scan and get requests, update all buttons at once in the scan cycle
    // ------------------------------------------------------------------
    assign lane_en = (state_reg == ST_SCAN) &&
                     ((item_reg.opcode == OP_SCAN) || (item_reg.opcode == OP_GET));

    for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
        // Buttons beyond the level field never read as pressed
        if (i < LEVEL_W) begin : g_pin
            assign down[i] = !item_reg.button_levels[i];
        end else begin : g_nopin
            assign down[i] = 1'b0;
        end

        kr_lane u_lane (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .en           (lane_en),
            .down         (down[i]),
            .now_time     (item_reg.now_time),
            .rep_offset   (rep_offset),
            .rep_interval (interval_reg),
            .rel_time     (release_reg),
            .push         (push_vec[i]),
            .pressed      (flags[i])
        );
    end

    for (genvar j = 0; j < MAP_W; j++) begin : g_map
        if (j < BUTTONS) begin : g_bit
            assign press_map[j] = flags[j];
        end else begin : g_zero
            assign press_map[j] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Merging stage and key queue
    // ------------------------------------------------------------------
    kr_queue #(
        .BUTTONS    (BUTTONS),
        .RING_SLOTS (RING_SLOTS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (qctl),
        .push_mask  (push_vec),
        .return_key (item_reg.return_key),
        .sts        (qsts),
        .held_key   (held_key),
        .ring_key   (ring_key)
    );

    // ------------------------------------------------------------------
    // Sequencer: accept, scan, merge pushes, resolve opcode, deliver
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign item_next = accept ? s_data : item_reg;

    always_comb begin
        state_next  = state_reg;
        qctl        = '0;
        out_load    = 1'b0;
        m_data_next = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // capture the lanes' new keys
                qctl.load  = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                // drain one key per cycle, lowest index first
                if (qsts.busy) begin
                    qctl.step = 1'b1;
                end else begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                // hold here while the previous result is still unclaimed
                if (out_free) begin
                    m_data_next.key_valid = 1'b0;
                    m_data_next.key_code  = '0;
                    m_data_next.press_map = press_map;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (item_reg.opcode)
                        OP_SCAN: ;
                        OP_GET: begin
                            if (qsts.held_valid) begin
                                qctl.get              = 1'b1;
                                m_data_next.key_valid = 1'b1;
                                m_data_next.key_code  = held_key;
                            end else if (qsts.ring_nonempty) begin
                                // launch the ring read; the read state delivers the key
                                qctl.get   = 1'b1;
                                out_load   = 1'b0;
                                state_next = ST_READ;
                            end
                        end
                        OP_FLUSH:  qctl.flush = 1'b1;
                        OP_RETURN: qctl.hold  = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                // output register is still free: nothing else loads it
                m_data_next.key_valid = 1'b1;
                m_data_next.key_code  = ring_key;
                m_data_next.press_map = press_map;
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN) && !s_ready)
        else $error("accepted request did not start a scan");

    a_nokey_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.key_valid) |-> (m_data_reg.key_code == '0))
        else $error("key code set on a result without a key");

    a_key_on_get: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_data_next.key_valid) |-> (item_reg.opcode == OP_GET))
        else $error("key returned for a request other than get");
`endif

endmodule

FILE: test/kr_tb_pkg.sv
// ----------------------------------------------------------------------------
// kr_tb_pkg
// Scoreboard for the keypad scanner bench: keeps its own copy of the button
// flags, repeat timers, key ring and return holder, predicts the result of
// every accepted request and compares the results that come back in order.
// ----------------------------------------------------------------------------
package kr_tb_pkg;

    import kr_pkg::*;

    localparam int SLOTS = 16;
    localparam int KEYS  = 8;

    class keypad_scoreboard;

        logic [CFG_W-1:0]  delay_cfg;
        logic [CFG_W-1:0]  interval_cfg;
        logic [CFG_W-1:0]  hold_off_cfg;

        bit                pressed     [KEYS];
        logic [TIME_W-1:0] repeat_base [KEYS];
        logic [TIME_W-1:0] last_down   [KEYS];
        logic [KEY_W-1:0]  ring        [SLOTS];
        logic [3:0]        wr_ptr;
        logic [3:0]        rd_ptr;
        logic [KEY_W-1:0]  held_key;
        bit                held_ok;

        kr_out_t           expected_results[$];

        int mismatches;
        int checked;
        int queued;
        int repeats;
        int dropped;
        int delivered;
        int from_holder;
        int empty_gets;
        int releases;

        function new();
            delay_cfg    = DELAY_RST;
            interval_cfg = INTERVAL_RST;
            hold_off_cfg = RELEASE_RST;
            for (int i = 0; i < KEYS; i++) begin
                pressed[i]     = 1'b0;
                repeat_base[i] = '0;
                last_down[i]   = '0;
            end
            for (int i = 0; i < SLOTS; i++)
                ring[i] = '0;
            wr_ptr   = '0;
            rd_ptr   = '0;
            held_key = '0;
            held_ok  = 1'b0;
        endfunction

        // only the low 31 bits of a register write are kept
        function void set_register(kr_reg_t idx, logic [APB_W-1:0] value);
            unique case (idx)
                REG_DELAY:    delay_cfg    = value[CFG_W-1:0];
                REG_INTERVAL: interval_cfg = value[CFG_W-1:0];
                REG_RELEASE:  hold_off_cfg = value[CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // signed wrapping difference; a negative one never reaches the limit
        function bit reached(logic [TIME_W-1:0] now_t, logic [TIME_W-1:0] then_t,
                             logic [CFG_W-1:0] limit);
            logic [TIME_W-1:0] d;
            d = now_t - then_t;
            return !d[TIME_W-1] && (d[CFG_W-1:0] >= limit);
        endfunction

        // keep one slot free; drop the key when the ring is full
        function void queue_key(logic [KEY_W-1:0] key);
            logic [3:0] nxt;
            nxt = wr_ptr + 4'd1;
            if (nxt == rd_ptr) begin
                dropped++;
            end else begin
                ring[wr_ptr] = key;
                wr_ptr = nxt;
                queued++;
            end
        endfunction

        function void scan_buttons(logic [TIME_W-1:0] t, logic [LEVEL_W-1:0] levels);
            for (int i = 0; i < KEYS; i++) begin
                if (!levels[i]) begin
                    if (!pressed[i]) begin
                        repeat_base[i] = t + ({1'b0, delay_cfg} - {1'b0, interval_cfg});
                        pressed[i] = 1'b1;
                        queue_key(KEY_W'(i));
                    end else if (reached(t, repeat_base[i], interval_cfg)) begin
                        repeat_base[i] = t;
                        repeats++;
                        queue_key(KEY_W'(i));
                    end
                    last_down[i] = t;
                end else if (pressed[i] && reached(t, last_down[i], hold_off_cfg)) begin
                    pressed[i] = 1'b0;
                    releases++;
                end
            end
        endfunction

        function void note_request(kr_in_t req);
            kr_out_t res;
            res = '0;
            case (req.opcode)
                OP_SCAN: scan_buttons(req.now_time, req.button_levels);
                OP_GET: begin
                    scan_buttons(req.now_time, req.button_levels);
                    if (held_ok) begin
                        held_ok = 1'b0;
                        res.key_valid = 1'b1;
                        res.key_code = held_key;
                        from_holder++;
                    end else if (rd_ptr != wr_ptr) begin
                        res.key_valid = 1'b1;
                        res.key_code = ring[rd_ptr];
                        rd_ptr = rd_ptr + 4'd1;
                        delivered++;
                    end else begin
                        empty_gets++;
                    end
                end
                OP_FLUSH: begin
                    rd_ptr = wr_ptr;
                    held_ok = 1'b0;
                end
                default: begin
                    held_key = req.return_key;
                    held_ok = 1'b1;
                end
            endcase
            for (int i = 0; i < KEYS; i++)
                res.press_map[i] = pressed[i];
            expected_results.push_back(res);
        endfunction

        function void check_result(kr_out_t got);
            kr_out_t want;
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with no request outstanding: %s",
                             checked,
                             $sformatf("valid=%0b code=%0d map=%02h",
                                       got.key_valid, got.key_code, got.press_map));
            end else begin
                want = expected_results.pop_front();
                if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
                    got.press_map !== want.press_map) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: want valid=%0b code=%0d map=%02h, %s",
                                 checked, want.key_valid, want.key_code, want.press_map,
                                 $sformatf("got valid=%0b code=%0d map=%02h",
                                           got.key_valid, got.key_code, got.press_map));
                end
            end
        endfunction

    endclass

endpackage

FILE: test/tb_keypad_repeat_fifo.sv
// ----------------------------------------------------------------------------
// tb_keypad_repeat_fifo
// Drives scan, get, flush and return requests into the keypad scanner under
// several repeat and release settings, with random gaps on both channels and
// one long result stall, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module tb_keypad_repeat_fifo;

    timeunit 1ns;
    timeprecision 1ps;

    import kr_pkg::*;
    import kr_tb_pkg::*;

    localparam int          IDLE_PCT      = 22;
    localparam int          STALL_CYCLES  = 400;
    localparam int          STALL_AT      = 300;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          PHASES        = 7;
    localparam int          PHASE_ITEMS   = 215;
    localparam logic [30:0] CFG_MAX       = 31'h7FFF_FFFF;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [APB_W-1:0]  pwdata  = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    kr_in_t            s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    kr_out_t           m_data;

    keypad_scoreboard  board;
    int                idle_pct = IDLE_PCT;
    int                cycles   = 0;
    int                accepted = 0;
    bit                stall_done = 1'b0;

    keypad_repeat_fifo #(
        .RING_SLOTS(16),
        .BUTTONS   (8)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit: far above the slowest correct run, stall and settling included.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_keypad_repeat_fifo: done, errors");
            $finish;
        end
    end

    // Check every result taken at a rising edge against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    // Result side: drop ready at random; once, after STALL_AT results, hold it
    // low for a long stretch so the block backs up and stalls its request side.
    initial begin : result_side
        forever begin
            @(negedge aclk);
            if (!stall_done && board != null && board.checked >= STALL_AT) begin
                stall_done = 1'b1;
                m_ready = 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
            end
            m_ready = ($urandom_range(99) >= idle_pct);
        end
    end

    // Offer one request; idle at random first, then hold it until accepted.
    task automatic offer_request(kr_op_t op, logic [TIME_W-1:0] t,
                                 logic [LEVEL_W-1:0] levels, logic [KEY_W-1:0] rk);
        kr_in_t req;
        req.opcode        = op;
        req.now_time      = t;
        req.button_levels = levels;
        req.return_key    = rk;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req);
        accepted++;
    endtask

    // Drop valid, wait for every predicted result, then let the pipe go quiet.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value on the
    // edge where the access completes.
    task automatic apb_write(kr_reg_t idx, logic [APB_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_register(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin : main_flow
        logic [TIME_W-1:0]  t0;
        logic [TIME_W-1:0]  now_t;
        logic [TIME_W-1:0]  step_max;
        logic [LEVEL_W-1:0] held;
        logic [LEVEL_W-1:0] levels;
        logic [CFG_W-1:0]   dly;
        logic [CFG_W-1:0]   ivl;
        logic [CFG_W-1:0]   hld;
        kr_op_t             op;
        int                 r;

        board = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed, reset settings: empty get, press of every button, holder
        // preferred over the ring, flush clearing ring and holder, release
        // hold-off, first repeat exactly at the delay, negative difference.
        t0 = 32'h0000_1000;
        offer_request(OP_SCAN,   t0, 8'hFF, 3'd0);
        offer_request(OP_GET,    t0, 8'hFF, 3'd7);
        offer_request(OP_SCAN,   t0, 8'h00, 3'd0);
        offer_request(OP_GET,    t0, 8'h00, 3'd0);
        offer_request(OP_RETURN, t0, 8'h00, 3'd5);
        offer_request(OP_GET,    t0, 8'h00, 3'd0);
        offer_request(OP_GET,    t0, 8'h00, 3'd0);
        offer_request(OP_FLUSH,  t0, 8'h00, 3'd0);
        offer_request(OP_GET,    t0, 8'h00, 3'd0);
        offer_request(OP_RETURN, t0, 8'h00, 3'd7);
        offer_request(OP_FLUSH,  t0, 8'h00, 3'd0);
        offer_request(OP_GET,    t0, 8'h00, 3'd0);
        offer_request(OP_SCAN,   t0 + 32'd399999, 8'h7E, 3'd0);
        offer_request(OP_SCAN,   t0 + 32'd400000, 8'h7E, 3'd0);
        offer_request(OP_SCAN,   t0 + 32'd399995, 8'h7E, 3'd0);
        offer_request(OP_GET,    t0 + 32'd400000, 8'h7E, 3'd0);
        offer_request(OP_GET,    t0 + 32'd400000, 8'h7E, 3'd0);
        offer_request(OP_GET,    t0 + 32'd400000, 8'h7E, 3'd0);
        offer_request(OP_SCAN,   32'hFFFF_FFF0, 8'hFF, 3'd0);

        // Directed, all-zero settings: time wraps, the buttons pressed after the wrap
        // repeat on each scan until the ring is full, then a zero hold-off releases.
        settle();
        apb_write(REG_DELAY,    32'h0);
        apb_write(REG_INTERVAL, 32'h0);
        apb_write(REG_RELEASE,  32'h0);
        repeat (4) offer_request(OP_SCAN, 32'd5, 8'h00, 3'd0);
        offer_request(OP_GET,  32'd5, 8'h00, 3'd0);
        offer_request(OP_GET,  32'd6, 8'h00, 3'd0);
        offer_request(OP_SCAN, 32'd6, 8'hFF, 3'd0);

        // Random phases: each with its own settings and time step, extremes
        // among them; phase 3 runs with no idling on the request side.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin dly = DELAY_RST; ivl = INTERVAL_RST; hld = RELEASE_RST;
                         step_max = 40000; end
                1: begin dly = '0; ivl = '0; hld = '0; step_max = 3; end
                2: begin dly = CFG_MAX; ivl = CFG_MAX; hld = CFG_MAX;
                         step_max = 32'h3000_0000; end
                3: begin dly = CFG_W'($urandom_range(200, 1));
                         ivl = CFG_W'($urandom_range(60, 1));
                         hld = CFG_W'($urandom_range(80, 1)); step_max = 40; end
                4: begin dly = CFG_MAX; ivl = '0; hld = '0; step_max = 1000; end
                5: begin dly = '0; ivl = CFG_MAX; hld = 31'd1000; step_max = 600; end
                default: begin dly = CFG_W'($urandom);
                         ivl = CFG_W'($urandom_range(5000, 0));
                         hld = CFG_W'($urandom_range(3000, 0)); step_max = 2000; end
            endcase
            settle();
            apb_write(REG_DELAY,    {1'($urandom_range(1)), dly});
            apb_write(REG_INTERVAL, {1'($urandom_range(1)), ivl});
            apb_write(REG_RELEASE,  {1'($urandom_range(1)), hld});
            idle_pct = (p == 3) ? 0 : IDLE_PCT;
            now_t = $urandom;
            held  = '0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Advance time mostly in steps, with jumps, steps back and
                // the exact half-range jump now and then.
                r = $urandom_range(99);
                if (r < 3)
                    now_t = now_t + $urandom;
                else if (r < 5)
                    now_t = now_t - $urandom_range(step_max, 0);
                else if (r < 7)
                    now_t = now_t + 32'h7FFF_FFFF;
                else
                    now_t = now_t + $urandom_range(step_max, 0);

                // Hold buttons down over many requests; mostly flip one at a time.
                r = $urandom_range(99);
                if (r < 12)
                    held[$urandom_range(LEVEL_W-1, 0)] ^= 1'b1;
                else if (r < 15)
                    held = LEVEL_W'($urandom);
                else if (r < 17)
                    held = {LEVEL_W{r[0]}};
                levels = ($urandom_range(99) < 5) ? LEVEL_W'($urandom) : ~held;

                r = $urandom_range(99);
                if (r < 50)
                    op = OP_SCAN;
                else if (r < 85)
                    op = OP_GET;
                else if (r < 90)
                    op = OP_FLUSH;
                else
                    op = OP_RETURN;
                offer_request(op, now_t, levels, KEY_W'($urandom_range(7, 0)));
            end
        end

        settle();
        $display("covered %0d requests in %0d setting phases: %0d keys queued, %0d repeats,",
                 accepted, PHASES + 2, board.queued, board.repeats);
        $display("  %0d dropped on a full ring, %0d releases; gets: %0d from the ring, %s",
                 board.dropped, board.releases, board.delivered,
                 $sformatf("%0d from the return holder, %0d empty; %0d results checked",
                           board.from_holder, board.empty_gets, board.checked));
        if (board.mismatches == 0) begin
            $display("tb_keypad_repeat_fifo: done, clean");
        end else begin
            $display("%0d mismatching results", board.mismatches);
            $display("tb_keypad_repeat_fifo: done, errors");
        end
        $finish;
    end

endmodule
